@@ rtl/raster_sync_line_timer_unit_macros.svh @@
// Assertion macros for the checker file of the raster sync line timer.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef RASTER_SYNC_LINE_TIMER_UNIT_MACROS_SVH
`define RASTER_SYNC_LINE_TIMER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RSLT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RSLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rslt_pkg.sv @@
// Shared types and constants of the raster sync line timer.
// Used by the interfaces, the divider, the top level and the checker.
package rslt_pkg;

	localparam int ACC_W           = 22;
	localparam int FIELD_W         = 10;
	localparam int IN_W            = 16;
	localparam int FRAME_CYCLES    = 3333333;
	localparam int CYCLES_PER_UNIT = 7;
	localparam int VBL_CLAMP_LIMIT = 600;
	localparam int VBL_CLAMP_VALUE = 500;

	// Largest divisor is CYCLES_PER_UNIT * 2^FIELD_W.
	localparam int DIV_W     = $clog2(CYCLES_PER_UNIT * (2 ** FIELD_W) + 1);
	localparam int CNT_W     = $clog2(ACC_W);
	localparam int NUM_REGS  = 5;
	localparam int CFG_IDX_W = $clog2(NUM_REGS);

	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_VBLANK_START = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_VBLANK_END   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_IRQ1    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_IRQ2    = CFG_IDX_W'(4);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_START,
		ST_DIV,
		ST_FLAGS
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic logic [DIV_W-1:0] calc_divisor(input logic [FIELD_W-1:0] len);
		calc_divisor = DIV_W'(CYCLES_PER_UNIT) * (DIV_W'(len) + DIV_W'(1));
	endfunction

endpackage

@@ rtl/rslt_sample_if.sv @@
// Input channel of the raster sync line timer: valid/ready plus the cycle count.
// Depends on rslt_pkg for the input width.
interface rslt_sample_if;
	logic                        valid;
	logic                        ready;
	logic [rslt_pkg::IN_W-1:0]   elapsed_cycles;

	modport source (output valid, output elapsed_cycles, input ready);
	modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

@@ rtl/rslt_result_if.sv @@
// Output channel of the raster sync line timer: valid/ready plus the status fields.
// Depends on rslt_pkg for the field width.
interface rslt_result_if;
	logic                         valid;
	logic                         ready;
	logic [rslt_pkg::FIELD_W-1:0] line_number;
	logic                         in_vblank;
	logic                         scan_irq1_pulse;
	logic                         scan_irq2_pulse;
	logic                         vblank_irq_pulse;

	modport source (output valid, output line_number, output in_vblank,
		output scan_irq1_pulse, output scan_irq2_pulse, output vblank_irq_pulse,
		input ready);
	modport sink   (input valid, input line_number, input in_vblank,
		input scan_irq1_pulse, input scan_irq2_pulse, input vblank_irq_pulse,
		output ready);
endinterface

@@ rtl/raster_sync_line_timer_unit.sv @@
// Raster sync line timer: frame cycle accumulator, line divider and interrupt flags.
// Use: each item on the sample channel carries elapsed_cycles, the CPU time elapsed since the
// previous update. The block adds it to the frame count, wraps the count by one frame
// length, divides it by 7 * (line_length + 1) to get the current line, and sends one
// item on the result channel with the line (low 10 bits), the vertical blank status
// and one-shot pulses for the two scanline interrupts and for vertical blank start.
// Configuration registers are written through cfg_we / cfg_index / cfg_data; the
// user must write them only while the block is idle, which the block does not
// enforce. Index 0 line_length, 1 vblank_start, 2 vblank_end, 3 and 4 the two scanline
// interrupt lines. Writes to other indexes are ignored.
// Sequence: the add happens at the accepting edge; then the frame wrap (ST_WRAP), the
// divider load (ST_START), the one-bit-per-cycle restoring divider up to its done flag
// (ST_DIV) and the flag evaluation (ST_FLAGS), which waits while the output register is
// full. sample.ready is high only while the sequencer is idle, so one item is in work at
// a time and a new item is not taken before the last one has left ST_FLAGS.
// The result sits in an output register; if the receiver stalls, the block still takes
// the next item and holds its finished result until the register frees up.
// Reset clears the frame count, internal flags, config registers and output valid bit.
// Depends on rslt_pkg, rslt_sample_if, rslt_result_if and rslt_divider.
module raster_sync_line_timer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	rslt_sample_if.sink                       sample,
	rslt_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [rslt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rslt_pkg::FIELD_W-1:0]      cfg_data
);

	rslt_pkg::state_t                state_q, state_d;
	logic [rslt_pkg::FIELD_W-1:0]    line_length_q;
	logic [rslt_pkg::FIELD_W-1:0]    vblank_start_q;
	logic [rslt_pkg::FIELD_W-1:0]    vblank_end_q;
	logic [rslt_pkg::FIELD_W-1:0]    scan_irq1_q;
	logic [rslt_pkg::FIELD_W-1:0]    scan_irq2_q;
	logic [rslt_pkg::ACC_W-1:0]      count_q;
	logic                            vblank_q;
	logic                            scan1_q;
	logic                            scan2_q;
	logic                            out_valid_q;
	logic [rslt_pkg::FIELD_W-1:0]    out_line_q;
	logic                            out_vblank_q;
	logic                            out_p1_q;
	logic                            out_p2_q;
	logic                            out_pv_q;

	logic                            accept;
	logic                            div_start;
	logic                            load_out;
	rslt_pkg::div_status_t           div_status;
	logic [rslt_pkg::ACC_W-1:0]      line;
	logic [rslt_pkg::FIELD_W-1:0]    vs;
	logic [rslt_pkg::ACC_W-1:0]      vs_x, ve_x;
	logic                            p1, p2, pv;
	logic                            vblank_d, scan1_d, scan2_d;

	assign accept = sample.valid && sample.ready;

	rslt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (count_q),
		.divisor  (rslt_pkg::calc_divisor(line_length_q)),
		.status   (div_status),
		.quotient (line)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rslt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		div_start    = 1'b0;
		load_out     = 1'b0;
		case (state_q)
			rslt_pkg::ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					state_d = rslt_pkg::ST_WRAP;
				end
			end
			rslt_pkg::ST_WRAP: begin
				state_d = rslt_pkg::ST_START;
			end
			rslt_pkg::ST_START: begin
				div_start = 1'b1;
				state_d   = rslt_pkg::ST_DIV;
			end
			rslt_pkg::ST_DIV: begin
				if (div_status.done) begin
					state_d = rslt_pkg::ST_FLAGS;
				end
			end
			rslt_pkg::ST_FLAGS: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = rslt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rslt_pkg::ST_IDLE;
			end
		endcase
	end

	// Interrupt and blank window evaluation on the full, unmasked line.
	always_comb begin
		vs = (vblank_start_q > rslt_pkg::FIELD_W'(rslt_pkg::VBL_CLAMP_LIMIT)) ?
			rslt_pkg::FIELD_W'(rslt_pkg::VBL_CLAMP_VALUE) : vblank_start_q;
		vs_x = rslt_pkg::ACC_W'(vs);
		ve_x = rslt_pkg::ACC_W'(vblank_end_q);
		p1 = (line >= rslt_pkg::ACC_W'(scan_irq1_q)) && !scan1_q;
		p2 = (line >= rslt_pkg::ACC_W'(scan_irq2_q)) && !scan2_q;
		scan1_d  = scan1_q || p1;
		scan2_d  = scan2_q || p2;
		vblank_d = vblank_q;
		pv       = 1'b0;
		if (vblank_end_q > vs) begin
			if (!vblank_d && vs_x <= line && ve_x > line) begin
				vblank_d = 1'b1;
				pv       = 1'b1;
			end
			if (vblank_d && ve_x <= line) begin
				vblank_d = 1'b0;
				scan1_d  = 1'b0;
				scan2_d  = 1'b0;
			end
		end else begin
			// The window wraps past the end of the frame.
			if (!vblank_d && vs_x <= line) begin
				vblank_d = 1'b1;
				pv       = 1'b1;
			end
			if (vblank_d && ve_x <= line && vs_x > line) begin
				vblank_d = 1'b0;
				scan1_d  = 1'b0;
				scan2_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q  <= '0;
			vblank_start_q <= '0;
			vblank_end_q   <= '0;
			scan_irq1_q    <= '0;
			scan_irq2_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rslt_pkg::REG_LINE_LENGTH:  line_length_q  <= cfg_data;
				rslt_pkg::REG_VBLANK_START: vblank_start_q <= cfg_data;
				rslt_pkg::REG_VBLANK_END:   vblank_end_q   <= cfg_data;
				rslt_pkg::REG_SCAN_IRQ1:    scan_irq1_q    <= cfg_data;
				rslt_pkg::REG_SCAN_IRQ2:    scan_irq2_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			vblank_q    <= 1'b0;
			scan1_q     <= 1'b0;
			scan2_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_q + rslt_pkg::ACC_W'(sample.elapsed_cycles);
			end else if (state_q == rslt_pkg::ST_WRAP &&
					count_q >= rslt_pkg::ACC_W'(rslt_pkg::FRAME_CYCLES)) begin
				count_q <= count_q - rslt_pkg::ACC_W'(rslt_pkg::FRAME_CYCLES);
			end
			if (load_out) begin
				vblank_q    <= vblank_d;
				scan1_q     <= scan1_d;
				scan2_q     <= scan2_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_line_q   <= line[rslt_pkg::FIELD_W-1:0];
			out_vblank_q <= vblank_d;
			out_p1_q     <= p1;
			out_p2_q     <= p2;
			out_pv_q     <= pv;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.line_number      = out_line_q;
	assign result.in_vblank        = out_vblank_q;
	assign result.scan_irq1_pulse  = out_p1_q;
	assign result.scan_irq2_pulse  = out_p2_q;
	assign result.vblank_irq_pulse = out_pv_q;

endmodule

@@ rtl/rslt_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the frame count over the line length.
// Depends on rslt_pkg for widths and the status struct.
module rslt_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rslt_pkg::ACC_W-1:0]    dividend,
	input  logic [rslt_pkg::DIV_W-1:0]    divisor,
	output rslt_pkg::div_status_t         status,
	output logic [rslt_pkg::ACC_W-1:0]    quotient
);

	logic                         running_q;
	logic                         done_q;
	logic [rslt_pkg::CNT_W-1:0]   cnt_q;
	logic [rslt_pkg::DIV_W-1:0]   rem_q;
	logic [rslt_pkg::ACC_W-1:0]   quo_q;
	logic [rslt_pkg::DIV_W-1:0]   dvs_q;
	logic [rslt_pkg::DIV_W:0]     trial;
	logic                         ge;
	logic [rslt_pkg::DIV_W:0]     trial_sub;

	// The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
	assign trial     = {rem_q, quo_q[rslt_pkg::ACC_W-1]};
	assign ge        = (trial >= {1'b0, dvs_q});
	assign trial_sub = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= rslt_pkg::CNT_W'(rslt_pkg::ACC_W - 1);
			end else if (running_q) begin
				cnt_q <= cnt_q - rslt_pkg::CNT_W'(1);
				if (cnt_q == '0) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (running_q) begin
			rem_q <= ge ? trial_sub[rslt_pkg::DIV_W-1:0] : trial[rslt_pkg::DIV_W-1:0];
			quo_q <= {quo_q[rslt_pkg::ACC_W-2:0], ge};
		end
	end

	assign status.busy = running_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

@@ rtl/rslt_checker.sv @@
// Port-level checks for the raster sync line timer, attached to the top level by bind.
// Depends on rslt_pkg and the macros in raster_sync_line_timer_unit_macros.svh.
`include "raster_sync_line_timer_unit_macros.svh"

module rslt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [rslt_pkg::FIELD_W-1:0]  line_number,
	input logic                          in_vblank,
	input logic                          vblank_irq_pulse
);

	// A stalled result keeps its line field.
	`RSLT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(line_number), "stalled result changed")

	// An item goes on to ST_WRAP and ST_START, so the block is busy right after taking one.
	`RSLT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready ##1 !in_ready, "ready too soon after accept")

	// A vertical blank start always leaves the block inside the blank window.
	`RSLT_ASSERT_SAME(a_pulse_in_blank, out_valid && vblank_irq_pulse, in_vblank, "vblank pulse outside blank")

	// A new result comes only from work on a taken item: ready was low when it was loaded.
	`RSLT_ASSERT_SAME(a_result_busy, out_valid && !$past(out_valid) && !$past(out_ready), !$past(in_ready), "result without work")

endmodule

bind raster_sync_line_timer_unit rslt_checker u_rslt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sample.valid),
	.in_ready         (sample.ready),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.line_number      (result.line_number),
	.in_vblank        (result.in_vblank),
	.vblank_irq_pulse (result.vblank_irq_pulse)
);
